FILE: rtl/core/svna_pkg.sv
// ----------------------------------------------------------------------------
// svna_pkg
// Shared types, widths, codes and helpers for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package svna_pkg;

    // default sizes handed to the top level
    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_MAX_CORNERS  = 16;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 12;
    localparam int POS_W  = 24;
    localparam int NRM_W  = 16;
    localparam int STAT_W = 2;

    // internal arithmetic widths
    localparam int DIFF_W  = POS_W + 1;          // edge vector component
    localparam int CROSS_W = 2 * DIFF_W;         // cross product component
    localparam int SUM_W   = 56;                 // saturating normal sum
    localparam int SUMX_W  = SUM_W + 1;          // sum before saturation
    localparam int MAG_W   = 30;                 // scaled magnitude
    localparam int MUL_W   = MAG_W + 1;          // signed multiplier operand
    localparam int PROD_W  = 2 * MUL_W;          // multiplier product
    localparam int SQ_W    = 62;                 // sum of squares
    localparam int RT_W    = SQ_W + 1;           // root iteration registers
    localparam int ROOT_W  = 31;                 // final root
    localparam int QUO_W   = 17;                 // division quotient bits
    localparam int FRAC_SH = 15;                 // Q1.15 scale shift
    localparam int DVD_W   = MAG_W + FRAC_SH + 1;
    localparam int REM_W   = ROOT_W;
    localparam int CNT_W   = 5;

    localparam int MIN_FACE_CORNERS = 3;
    localparam int NRM_MAX          = 32767;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CORNER = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROP  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } t_diff;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_sum;

    // commands to the root and divide unit
    typedef struct packed {
        logic sqrt_go;
        logic div_go;
    } t_sd_cmd;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_CMP,
        S_FETCH,
        S_X_MUL,
        S_X_ACC,
        S_ACC_RD,
        S_ACC_SUM,
        S_ACC_ADD,
        S_N_MAG,
        S_N_SHIFT,
        S_Q_MUL,
        S_Q_ACC,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT
    } t_state;

    // saturating add of a face normal component to a running sum
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]   s,
        input logic signed [CROSS_W-1:0] d
    );
        logic signed [SUMX_W-1:0] t;
        t = SUMX_W'(s) + SUMX_W'(d);
        if (t[SUMX_W-1] != t[SUMX_W-2]) begin
            sat_add = t[SUMX_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat_add = t[SUM_W-1:0];
        end
    endfunction

    // magnitude of a signed sum, the most negative value included
    function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
        mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

endpackage

FILE: rtl/core/svna_root_div.sv
// ----------------------------------------------------------------------------
// svna_root_div
// Bit-serial integer square root and restoring divider sharing one unit.
// ----------------------------------------------------------------------------
module svna_root_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  svna_pkg::t_sd_cmd            i_cmd,
    input  logic [svna_pkg::SQ_W-1:0]    i_rad,
    input  logic [svna_pkg::MAG_W-1:0]   i_num,
    output logic                         o_done,
    output logic [svna_pkg::QUO_W-1:0]   o_quot
);
    import svna_pkg::*;

    logic              r_busy;
    logic              r_is_div;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_s;
    logic [RT_W-1:0]   r_r;
    logic [RT_W-1:0]   r_bit;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_dq;

    logic [RT_W:0]     sq_trial;
    logic              sq_ge;
    logic [RT_W-1:0]   n_r;
    logic [REM_W:0]    dv_rem2;
    logic              dv_ge;
    logic [REM_W:0]    dv_diff;
    logic [DVD_W-1:0]  dv_init;
    logic              last_step;

    // one root step per cycle
    always_comb begin
        sq_trial = (RT_W+1)'(r_r) + (RT_W+1)'(r_bit);
        sq_ge    = (RT_W+1)'(r_s) >= sq_trial;
        n_r      = sq_ge ? (r_r >> 1) + r_bit : (r_r >> 1);
    end

    // one quotient bit per cycle
    always_comb begin
        dv_rem2 = {r_rem, r_dq[QUO_W-1]};
        dv_ge   = dv_rem2 >= (REM_W+1)'(r_root);
        dv_diff = dv_rem2 - (REM_W+1)'(r_root);
        dv_init = (DVD_W'(i_num) << FRAC_SH) + DVD_W'(r_root >> 1);
    end

    // root walks the trial bit from 2^62 down to 2^0, 32 steps
    assign last_step = r_is_div ? (r_cnt == CNT_W'(QUO_W - 1))
                                : (r_cnt == CNT_W'(ROOT_W));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_is_div <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.sqrt_go || i_cmd.div_go) begin
                r_busy   <= 1'b1;
                r_is_div <= i_cmd.div_go;
                r_cnt    <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_go) begin
            r_s   <= i_rad;
            r_r   <= '0;
            r_bit <= RT_W'(1) << SQ_W;
        end else if (i_cmd.div_go) begin
            r_rem <= REM_W'(dv_init >> QUO_W);
            r_dq  <= dv_init[QUO_W-1:0];
        end else if (r_busy && !r_is_div) begin
            if (sq_ge) begin
                r_s <= r_s - sq_trial[SQ_W-1:0];
            end
            r_r   <= n_r;
            r_bit <= r_bit >> 2;
            if (last_step) begin
                r_root <= n_r[ROOT_W-1:0];
            end
        end else if (r_busy) begin
            r_rem <= dv_ge ? dv_diff[REM_W-1:0] : dv_rem2[REM_W-1:0];
            r_dq  <= {r_dq[QUO_W-2:0], dv_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

FILE: rtl/core/smooth_vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator
// Area-weighted smooth vertex normals: position store, face accumulation and
// normalized readout, built around one shared multiplier and a serial unit.
// ----------------------------------------------------------------------------
// One transaction is accepted at a time and gives exactly one result. Load,
// clear, a corner that does not end a face, a dropped face and a read out of
// range are answered from the idle state. A face end checks the index of each
// buffered corner, fetches three positions, forms the cross product on the
// shared multiplier and does a read-modify-write of the sums for each corner
// in the sum memory. A read fetches the sums, scales the magnitudes by shifts
// of one bit at a time (up to 29), forms the squares, takes the bit-serial
// root and does a serial divide per component. No clearing pass is needed
// after reset.
module smooth_vertex_normal_accumulator #(
    parameter int MAX_VERTICES = svna_pkg::DEF_MAX_VERTICES,
    parameter int MAX_CORNERS  = svna_pkg::DEF_MAX_CORNERS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [svna_pkg::OP_W-1:0]           i_opcode,
    input  logic [svna_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [svna_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [svna_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [svna_pkg::POS_W-1:0]   i_pos_z,
    input  logic                                i_last_corner,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [svna_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [svna_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [svna_pkg::NRM_W-1:0]   o_normal_z,
    output logic [svna_pkg::STAT_W-1:0]         o_status
);
    import svna_pkg::*;

    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int VC_W  = $clog2(MAX_VERTICES + 1);
    localparam int CA_W  = $clog2(MAX_CORNERS);
    localparam int CC_W  = $clog2(MAX_CORNERS + 1);
    localparam int KW    = (CC_W > 3) ? CC_W : 3;
    localparam int CMP_W = (VC_W > IDX_W) ? VC_W : IDX_W;

    // state
    t_state r_state, n_state;
    logic [VC_W-1:0] r_loaded;
    logic [CC_W-1:0] r_held;
    logic            r_invalid;
    logic [KW-1:0]   r_k;

    // memories
    t_pos            pos_mem [MAX_VERTICES];
    t_sum            sum_mem [MAX_VERTICES];
    logic [IDX_W-1:0] cb_mem [MAX_CORNERS];
    t_pos            r_pos_rd;
    t_sum            r_sum_rd;
    logic [IDX_W-1:0] r_cb_rd;

    // datapath registers
    t_pos                      r_pa;
    t_diff                     r_u;
    t_diff                     r_v;
    logic signed [CROSS_W-1:0] r_n [3];
    logic signed [PROD_W-1:0]  r_prod;
    logic [SUM_W-1:0]          r_m [3];
    logic                      r_neg [3];
    logic [SQ_W-1:0]           r_s;
    logic signed [NRM_W-1:0]   r_q [2];

    // output register
    logic                    r_out_valid;
    logic signed [NRM_W-1:0] r_nx, r_ny, r_nz;
    logic [STAT_W-1:0]       r_status;

    // control and combinational datapath
    logic                    accept;
    logic                    idx_ok;
    logic                    held_full;
    logic [CC_W-1:0]         n_held_acc;
    logic                    face_ok;
    logic                    chk_bad;
    logic                    k_last_corner;
    logic [SUM_W-1:0]        m_top;
    logic                    pos_we;
    logic                    sum_we;
    logic [VA_W-1:0]         sum_waddr;
    t_sum                    sum_wdata;
    logic                    cb_we;
    logic [CA_W-1:0]         cb_raddr;
    logic [VA_W-1:0]         pos_raddr;
    logic [VA_W-1:0]         sum_raddr;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    t_sd_cmd                 sd_cmd;
    logic                    sd_done;
    logic [QUO_W-1:0]        sd_quot;
    logic [NRM_W-1:0]        q_mag;
    logic signed [NRM_W-1:0] q_comp;
    logic                    out_load;
    logic [STAT_W-1:0]       out_status;
    logic signed [NRM_W-1:0] out_nx, out_ny, out_nz;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    // accept-time decisions and sequencer conditions
    always_comb begin
        idx_ok        = CMP_W'(i_vertex_index) < CMP_W'(r_loaded);
        held_full     = r_held == CC_W'(MAX_CORNERS);
        n_held_acc    = held_full ? r_held : r_held + CC_W'(1);
        face_ok       = !(r_invalid || held_full) && (n_held_acc >= CC_W'(MIN_FACE_CORNERS));
        chk_bad       = CMP_W'(r_cb_rd) >= CMP_W'(r_loaded);
        k_last_corner = r_k == KW'(r_held - CC_W'(1));
        m_top         = r_m[0] | r_m[1] | r_m[2];
    end

    // memory addresses
    assign cb_raddr  = r_k[CA_W-1:0];
    assign pos_raddr = VA_W'(r_cb_rd);
    assign sum_raddr = (r_state == S_IDLE) ? VA_W'(i_vertex_index) : VA_W'(r_cb_rd);

    // clamp and sign the quotient of the current component
    always_comb begin
        q_mag  = (sd_quot > QUO_W'(NRM_MAX)) ? NRM_W'(NRM_MAX) : NRM_W'(sd_quot);
        q_comp = r_neg[r_k[1:0]] ? -$signed(q_mag) : $signed(q_mag);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_CORNER && i_last_corner && face_ok) begin
                        n_state = S_CHK_RD;
                    end else if (i_opcode == OP_READ && idx_ok) begin
                        n_state = S_N_MAG;
                    end
                end
            end
            S_CHK_RD:  n_state = S_CHK_CMP;
            S_CHK_CMP: begin
                priority if (chk_bad) begin
                    n_state = S_IDLE;
                end else if (k_last_corner) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_CHK_RD;
                end
            end
            S_FETCH:     n_state = (r_k == KW'(4)) ? S_X_MUL : S_FETCH;
            S_X_MUL:     n_state = S_X_ACC;
            S_X_ACC:     n_state = (r_k == KW'(5)) ? S_ACC_RD : S_X_MUL;
            S_ACC_RD:    n_state = S_ACC_SUM;
            S_ACC_SUM:   n_state = S_ACC_ADD;
            S_ACC_ADD:   n_state = k_last_corner ? S_IDLE : S_ACC_RD;
            S_N_MAG:     n_state = (mag(r_sum_rd.x) | mag(r_sum_rd.y) | mag(r_sum_rd.z)) == '0
                                   ? S_IDLE : S_N_SHIFT;
            S_N_SHIFT:   n_state = (m_top[SUM_W-1:MAG_W] == '0 && m_top[MAG_W-1])
                                   ? S_Q_MUL : S_N_SHIFT;
            S_Q_MUL:     n_state = S_Q_ACC;
            S_Q_ACC:     n_state = (r_k == KW'(2)) ? S_ROOT_GO : S_Q_MUL;
            S_ROOT_GO:   n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: n_state = sd_done ? S_DIV_GO : S_ROOT_WAIT;
            S_DIV_GO:    n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (sd_done) begin
                    n_state = (r_k == KW'(2)) ? S_IDLE : S_DIV_GO;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        pos_we     = 1'b0;
        sum_we     = 1'b0;
        sum_waddr  = r_loaded[VA_W-1:0];
        sum_wdata  = '0;
        cb_we      = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        sd_cmd     = '0;
        out_load   = 1'b0;
        out_status = ST_OK;
        out_nx     = '0;
        out_ny     = '0;
        out_nz     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_LOAD: begin
                            out_load = 1'b1;
                            if (r_loaded == VC_W'(MAX_VERTICES)) begin
                                out_status = ST_FULL;
                            end else begin
                                pos_we = 1'b1;
                                sum_we = 1'b1;
                            end
                        end
                        OP_CORNER: begin
                            cb_we    = !held_full;
                            out_load = !(i_last_corner && face_ok);
                            if (i_last_corner && !face_ok) begin
                                out_status = ST_DROP;
                            end
                        end
                        OP_READ: begin
                            out_load = !idx_ok;
                            if (!idx_ok) begin
                                out_status = ST_RANGE;
                            end
                        end
                        OP_CLEAR: out_load = 1'b1;
                        default:  out_load = 1'b1;
                    endcase
                end
            end
            S_CHK_CMP: begin
                if (chk_bad) begin
                    out_load   = 1'b1;
                    out_status = ST_DROP;
                end
            end
            S_X_MUL: begin
                unique case (r_k[2:0])
                    3'd0: begin mul_a = MUL_W'(r_u.y); mul_b = MUL_W'(r_v.z); end
                    3'd1: begin mul_a = MUL_W'(r_u.z); mul_b = MUL_W'(r_v.y); end
                    3'd2: begin mul_a = MUL_W'(r_u.z); mul_b = MUL_W'(r_v.x); end
                    3'd3: begin mul_a = MUL_W'(r_u.x); mul_b = MUL_W'(r_v.z); end
                    3'd4: begin mul_a = MUL_W'(r_u.x); mul_b = MUL_W'(r_v.y); end
                    default: begin mul_a = MUL_W'(r_u.y); mul_b = MUL_W'(r_v.x); end
                endcase
            end
            S_ACC_ADD: begin
                sum_we      = 1'b1;
                sum_waddr   = VA_W'(r_cb_rd);
                sum_wdata.x = sat_add(r_sum_rd.x, r_n[0]);
                sum_wdata.y = sat_add(r_sum_rd.y, r_n[1]);
                sum_wdata.z = sat_add(r_sum_rd.z, r_n[2]);
                out_load    = k_last_corner;
            end
            S_N_MAG: begin
                if ((mag(r_sum_rd.x) | mag(r_sum_rd.y) | mag(r_sum_rd.z)) == '0) begin
                    out_load = 1'b1;
                end
            end
            S_Q_MUL: begin
                mul_a = $signed({1'b0, r_m[r_k[1:0]][MAG_W-1:0]});
                mul_b = $signed({1'b0, r_m[r_k[1:0]][MAG_W-1:0]});
            end
            S_ROOT_GO: sd_cmd.sqrt_go = 1'b1;
            S_DIV_GO:  sd_cmd.div_go  = 1'b1;
            S_DIV_WAIT: begin
                if (sd_done && r_k == KW'(2)) begin
                    out_load = 1'b1;
                    out_nx   = r_q[0];
                    out_ny   = r_q[1];
                    out_nz   = q_comp;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_loaded  <= '0;
            r_held    <= '0;
            r_invalid <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (accept) begin
                        unique case (i_opcode)
                            OP_LOAD: begin
                                if (r_loaded != VC_W'(MAX_VERTICES)) begin
                                    r_loaded <= r_loaded + VC_W'(1);
                                end
                            end
                            OP_CORNER: begin
                                r_held    <= (i_last_corner && !face_ok) ? '0 : n_held_acc;
                                r_invalid <= i_last_corner ? 1'b0 : (r_invalid || held_full);
                            end
                            OP_CLEAR: begin
                                r_loaded  <= '0;
                                r_held    <= '0;
                                r_invalid <= 1'b0;
                            end
                            default: begin
                                r_k <= '0;
                            end
                        endcase
                    end
                end
                S_CHK_CMP: begin
                    priority if (chk_bad) begin
                        r_held <= '0;
                    end else if (k_last_corner) begin
                        r_k <= '0;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_FETCH: r_k <= (r_k == KW'(4)) ? '0 : r_k + KW'(1);
                S_X_ACC: r_k <= (r_k == KW'(5)) ? '0 : r_k + KW'(1);
                S_ACC_ADD: begin
                    if (k_last_corner) begin
                        r_k       <= '0;
                        r_held    <= '0;
                        r_invalid <= 1'b0;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_Q_ACC:  r_k <= (r_k == KW'(2)) ? '0 : r_k + KW'(1);
                S_DIV_WAIT: begin
                    if (sd_done) begin
                        r_k <= (r_k == KW'(2)) ? '0 : r_k + KW'(1);
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_FETCH: begin
                if (r_k == KW'(2)) begin
                    r_pa <= r_pos_rd;
                end
                if (r_k == KW'(3)) begin
                    r_u.x <= DIFF_W'(r_pos_rd.x) - DIFF_W'(r_pa.x);
                    r_u.y <= DIFF_W'(r_pos_rd.y) - DIFF_W'(r_pa.y);
                    r_u.z <= DIFF_W'(r_pos_rd.z) - DIFF_W'(r_pa.z);
                end
                if (r_k == KW'(4)) begin
                    r_v.x <= DIFF_W'(r_pos_rd.x) - DIFF_W'(r_pa.x);
                    r_v.y <= DIFF_W'(r_pos_rd.y) - DIFF_W'(r_pa.y);
                    r_v.z <= DIFF_W'(r_pos_rd.z) - DIFF_W'(r_pa.z);
                end
            end
            S_X_MUL, S_Q_MUL: r_prod <= mul_a * mul_b;
            S_X_ACC: begin
                if (!r_k[0]) begin
                    r_n[r_k[2:1]] <= CROSS_W'(r_prod);
                end else begin
                    r_n[r_k[2:1]] <= r_n[r_k[2:1]] - CROSS_W'(r_prod);
                end
            end
            S_N_MAG: begin
                r_m[0]   <= mag(r_sum_rd.x);
                r_m[1]   <= mag(r_sum_rd.y);
                r_m[2]   <= mag(r_sum_rd.z);
                r_neg[0] <= r_sum_rd.x[SUM_W-1];
                r_neg[1] <= r_sum_rd.y[SUM_W-1];
                r_neg[2] <= r_sum_rd.z[SUM_W-1];
            end
            S_N_SHIFT: begin
                // one bit per cycle until the largest lies in [2^29, 2^30)
                if (m_top[SUM_W-1:MAG_W] != '0) begin
                    r_m[0] <= r_m[0] >> 1;
                    r_m[1] <= r_m[1] >> 1;
                    r_m[2] <= r_m[2] >> 1;
                end else if (!m_top[MAG_W-1]) begin
                    r_m[0] <= r_m[0] << 1;
                    r_m[1] <= r_m[1] << 1;
                    r_m[2] <= r_m[2] << 1;
                end
            end
            S_Q_ACC: r_s <= (r_k == '0) ? SQ_W'(r_prod) : r_s + SQ_W'(r_prod);
            S_DIV_WAIT: begin
                if (sd_done && r_k != KW'(2)) begin
                    r_q[r_k[0]] <= q_comp;
                end
            end
            default: begin
                r_s <= r_s;
            end
        endcase
    end

    // position store
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[r_loaded[VA_W-1:0]] <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        r_pos_rd <= pos_mem[pos_raddr];
    end

    // normal sum store
    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        r_sum_rd <= sum_mem[sum_raddr];
    end

    // corner buffer
    always_ff @(posedge i_clk) begin
        if (cb_we) begin
            cb_mem[r_held[CA_W-1:0]] <= i_vertex_index;
        end
        r_cb_rd <= cb_mem[cb_raddr];
    end

    // root and divide unit
    svna_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sd_cmd),
        .i_rad   (r_s),
        .i_num   (r_m[r_k[1:0]][MAG_W-1:0]),
        .o_done  (sd_done),
        .o_quot  (sd_quot)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_nx     <= out_nx;
            r_ny     <= out_ny;
            r_nz     <= out_nz;
            r_status <= out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_normal_x  = r_nx;
    assign o_normal_y  = r_ny;
    assign o_normal_z  = r_nz;
    assign o_status    = r_status;

endmodule
